[hdl/keyed_summary_merge_table_unit_macros.svh]
// Assertion macros for the keyed summary merge table
`ifndef KEYED_SUMMARY_MERGE_TABLE_UNIT_MACROS_SVH
`define KEYED_SUMMARY_MERGE_TABLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every edge out of reset
`define KSMT_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("ksmt check failed");

// same-cycle implication
`define KSMT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ksmt check failed");

// next-cycle implication
`define KSMT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ksmt check failed");

`else

`define KSMT_ASSERT(label, cond)
`define KSMT_ASSERT_IMP(label, ante, cons)
`define KSMT_ASSERT_NXT(label, ante, cons)

`endif

`endif

[hdl/ksmt_pkg.sv]
// Types and constants for the keyed summary merge table
`timescale 1ns / 1ps
`default_nettype none

package ksmt_pkg;

  localparam int SLOTS     = 256;
  localparam int SLOT_AW   = $clog2(SLOTS);
  localparam int KEY_W     = 64;
  localparam int SEC_W     = 32;
  localparam int HALF_W    = 16;
  localparam int SLOT_W    = 8;
  localparam int CNT_W     = 9;
  localparam int STATUS_W  = 3;
  localparam int ACTION_W  = 2;

  localparam logic [SLOT_AW-1:0] LAST_SLOT  = SLOT_AW'(SLOTS - 1);
  localparam logic [CNT_W-1:0]   CNT_MAX    = '1;
  localparam logic [HALF_W-1:0]  LAUNCH_MAX = '1;
  localparam logic [KEY_W-1:0]   EMPTY_KEY  = '1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_MERGE,
    ACT_READ,
    ACT_BATCH,
    ACT_CLEAR
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE,
    ST_SKIPPED,
    ST_MERGED,
    ST_KEPT,
    ST_ADDED,
    ST_FULL,
    ST_IGNORED
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [SEC_W-1:0]  seconds;
    logic [HALF_W-1:0] launches;
    logic [HALF_W-1:0] first_day;
    logic [HALF_W-1:0] last_day;
  } entry_t;

  localparam entry_t EMPTY_ENTRY = '{
    key:       EMPTY_KEY,
    seconds:   '0,
    launches:  '0,
    first_day: '0,
    last_day:  '0
  };

  function automatic logic key_empty(input logic [KEY_W-1:0] k);
    return (k == EMPTY_KEY) || (k == '0);
  endfunction

endpackage

`default_nettype wire

[hdl/keyed_summary_merge_table_unit.sv]
// Keyed summary merge table: slot memory, scan sequencer and result register
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_we               cfg_wdata (keep_existing)
//   in       in         in_valid / in_ready  action key seconds launches
//                                            first_day last_day slot
//   out      out        out_valid / out_ready status where entry_* live_entries
//                                            added_in_batch
//
// Merge request: scan, update and emit states; the scan reads one slot per
//   cycle through the single read port of the slot memory.
// Read request: read, then emit. Batch start, clear, skipped and ignored merges: emit only.
// Reset and clear take effect at once through per-slot valid bits.
// A finished result waits in the output register; the next request is
// accepted meanwhile and holds only at its own result stage.
`timescale 1ns / 1ps
`default_nettype none

`include "keyed_summary_merge_table_unit_macros.svh"

module keyed_summary_merge_table_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic                                cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ksmt_pkg::ACTION_W-1:0]       action,
  input  logic [ksmt_pkg::KEY_W-1:0]          key,
  input  logic [ksmt_pkg::SEC_W-1:0]          seconds,
  input  logic [ksmt_pkg::HALF_W-1:0]         launches,
  input  logic [ksmt_pkg::HALF_W-1:0]         first_day,
  input  logic [ksmt_pkg::HALF_W-1:0]         last_day,
  input  logic [ksmt_pkg::SLOT_W-1:0]         slot,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ksmt_pkg::STATUS_W-1:0]       status,
  output logic [ksmt_pkg::SLOT_W-1:0]         where,
  output logic [ksmt_pkg::KEY_W-1:0]          entry_key,
  output logic [ksmt_pkg::SEC_W-1:0]          entry_seconds,
  output logic [ksmt_pkg::HALF_W-1:0]         entry_launches,
  output logic [ksmt_pkg::HALF_W-1:0]         entry_first_day,
  output logic [ksmt_pkg::HALF_W-1:0]         entry_last_day,
  output logic [ksmt_pkg::CNT_W-1:0]          live_entries,
  output logic [ksmt_pkg::CNT_W-1:0]          added_in_batch
);
  import ksmt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_READ,
    S_EMIT
  } state_t;

  state_t               state;
  logic                 keep_existing;
  logic [CNT_W-1:0]     live_total;
  logic [CNT_W-1:0]     batch_added;
  logic                 batch_failed;
  logic [SLOTS-1:0]     slot_valid;

  entry_t               mem [SLOTS];
  logic [SLOT_AW-1:0]   rd_addr;
  entry_t               rd_data;
  logic                 rd_vld;
  entry_t               rd_ent;

  logic                 mem_we;
  logic [SLOT_AW-1:0]   mem_wa;
  entry_t               mem_wd;

  logic [KEY_W-1:0]     op_key;
  logic [SEC_W-1:0]     op_sec;
  logic [HALF_W-1:0]    op_lau;
  logic [HALF_W-1:0]    op_fd;
  logic [HALF_W-1:0]    op_ld;
  logic [SLOT_W-1:0]    op_slot;
  logic                 op_in_range;

  logic [SLOT_AW-1:0]   scan_idx;
  logic [SLOT_AW-1:0]   chk_idx;
  logic                 issue_on;
  logic                 chk_on;

  logic                 found_hit;
  logic [SLOT_AW-1:0]   found_idx;
  entry_t               found_ent;
  logic                 free_hit;
  logic [SLOT_AW-1:0]   free_idx;

  status_t              res_status;
  logic [SLOT_W-1:0]    res_where;
  entry_t               res_ent;

  logic                 accept;
  logic [HALF_W:0]      lau_sum;
  entry_t               merged;
  entry_t               new_ent;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (state == S_IDLE) begin
      rd_addr = SLOT_AW'(slot);
    end else begin
      rd_addr = scan_idx;
    end
  end

  assign rd_ent = rd_vld ? rd_data : EMPTY_ENTRY;

  always_comb begin
    lau_sum            = {1'b0, found_ent.launches} + {1'b0, op_lau};
    merged.key         = found_ent.key;
    merged.seconds     = found_ent.seconds + op_sec;
    merged.launches    = lau_sum[HALF_W] ? LAUNCH_MAX : lau_sum[HALF_W-1:0];
    merged.first_day   = (op_fd < found_ent.first_day) ? op_fd : found_ent.first_day;
    merged.last_day    = (op_ld > found_ent.last_day) ? op_ld : found_ent.last_day;
    new_ent.key        = op_key;
    new_ent.seconds    = op_sec;
    new_ent.launches   = op_lau;
    new_ent.first_day  = op_fd;
    new_ent.last_day   = op_ld;
  end

  always_comb begin
    mem_we = (state == S_UPDATE) &&
             ((found_hit && !keep_existing) || (!found_hit && free_hit));
    mem_wa = found_hit ? found_idx : free_idx;
    mem_wd = found_hit ? merged : new_ent;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      keep_existing <= 1'b0;
      live_total    <= '0;
      batch_added   <= '0;
      batch_failed  <= 1'b0;
      slot_valid    <= '0;
      out_valid     <= 1'b0;
      issue_on      <= 1'b0;
      chk_on        <= 1'b0;
      found_hit     <= 1'b0;
      free_hit      <= 1'b0;
    end else begin
      if (cfg_we) begin
        keep_existing <= cfg_wdata;
      end
      if (out_valid && out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      rd_vld  <= slot_valid[rd_addr];
      chk_on  <= issue_on;
      chk_idx <= scan_idx;

      case (state)
        S_IDLE: begin
          if (accept) begin
            op_key      <= key;
            op_sec      <= seconds;
            op_lau      <= launches;
            op_fd       <= first_day;
            op_ld       <= last_day;
            op_slot     <= slot;
            op_in_range <= (32'(slot) < SLOTS);
            res_status  <= ST_DONE;
            res_where   <= '0;
            res_ent     <= '0;
            case (action_t'(action))
              ACT_MERGE: begin
                if (batch_failed) begin
                  res_status <= ST_IGNORED;
                  state      <= S_EMIT;
                end else if (key_empty(key)) begin
                  res_status <= ST_SKIPPED;
                  state      <= S_EMIT;
                end else begin
                  scan_idx  <= '0;
                  issue_on  <= 1'b1;
                  found_hit <= 1'b0;
                  free_hit  <= 1'b0;
                  state     <= S_SCAN;
                end
              end
              ACT_READ: begin
                state <= S_READ;
              end
              ACT_BATCH: begin
                batch_added  <= '0;
                batch_failed <= 1'b0;
                state        <= S_EMIT;
              end
              ACT_CLEAR: begin
                slot_valid   <= '0;
                live_total   <= '0;
                batch_added  <= '0;
                batch_failed <= 1'b0;
                state        <= S_EMIT;
              end
              default: begin
                state <= S_EMIT;
              end
            endcase
          end
        end

        S_SCAN: begin
          if (issue_on) begin
            if (scan_idx == LAST_SLOT) begin
              issue_on <= 1'b0;
            end else begin
              scan_idx <= scan_idx + 1'b1;
            end
          end
          if (chk_on) begin
            if (!found_hit && (rd_ent.key == op_key)) begin
              found_hit <= 1'b1;
              found_idx <= chk_idx;
              found_ent <= rd_ent;
            end
            if (!free_hit && key_empty(rd_ent.key)) begin
              free_hit <= 1'b1;
              free_idx <= chk_idx;
            end
            if (chk_idx == LAST_SLOT) begin
              state <= S_UPDATE;
            end
          end
        end

        S_UPDATE: begin
          if (found_hit) begin
            res_where <= SLOT_W'(found_idx);
            if (keep_existing) begin
              res_status <= ST_KEPT;
              res_ent    <= found_ent;
            end else begin
              res_status <= ST_MERGED;
              res_ent    <= merged;
            end
          end else if (free_hit) begin
            res_status           <= ST_ADDED;
            res_where            <= SLOT_W'(free_idx);
            res_ent              <= new_ent;
            slot_valid[free_idx] <= 1'b1;
            if (live_total != CNT_MAX) begin
              live_total <= live_total + 1'b1;
            end
            if (batch_added != CNT_MAX) begin
              batch_added <= batch_added + 1'b1;
            end
          end else begin
            res_status   <= ST_FULL;
            batch_failed <= 1'b1;
          end
          state <= S_EMIT;
        end

        S_READ: begin
          res_where <= op_slot;
          res_ent   <= op_in_range ? rd_ent : EMPTY_ENTRY;
          state     <= S_EMIT;
        end

        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            status          <= res_status;
            where           <= res_where;
            entry_key       <= res_ent.key;
            entry_seconds   <= res_ent.seconds;
            entry_launches  <= res_ent.launches;
            entry_first_day <= res_ent.first_day;
            entry_last_day  <= res_ent.last_day;
            live_entries    <= live_total;
            added_in_batch  <= batch_added;
            state           <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `KSMT_ASSERT(a_live_ge_batch, live_total >= batch_added)
  `KSMT_ASSERT(a_live_matches_valid, 32'(live_total) == $countones(slot_valid))
  `KSMT_ASSERT_NXT(a_scan_ends, chk_on && (chk_idx == LAST_SLOT), state == S_UPDATE)
  `KSMT_ASSERT_IMP(a_write_in_update, mem_we, (state == S_UPDATE) && (found_hit || free_hit))

endmodule

`default_nettype wire
